// ----- rtl/sbc_pkg.sv -----
// shared types and constants for the source bracket syntax checker
package sbc_pkg;

    // default sizes of the depth counters and the line counter
    localparam int DEPTH_BITS_DEF = 8;
    localparam int LINE_BITS_DEF  = 16;

    // width of the reported line field
    localparam int ERR_LINE_W = 16;

    // scan mode codes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_F      = 2'd1;
    localparam logic [1:0] MODE_FO     = 2'd2;
    localparam logic [1:0] MODE_HEADER = 2'd3;

    // error kind codes
    localparam logic [1:0] KIND_PAREN = 2'd0;
    localparam logic [1:0] KIND_BRACE = 2'd1;
    localparam logic [1:0] KIND_FOR   = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_O      = 8'h6F;
    localparam logic [7:0] CHAR_R      = 8'h72;

    // semicolons a well formed for header holds, and the saturation point
    localparam logic [1:0] SEMI_GOOD = 2'd2;
    localparam logic [1:0] SEMI_MAX  = 2'd3;

    // result of one scan step
    typedef struct packed {
        logic                  err;
        logic [1:0]            kind;
        logic [ERR_LINE_W-1:0] line;
    } t_scan_result;

endpackage

// ----- rtl/sbc_scan_core.sv -----
// scan state registers and the per-beat next-state and error logic
module sbc_scan_core
    import sbc_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic [7:0]   i_byte,
    output t_scan_result o_result
);

    logic [1:0]            r_mode,  n_mode;
    logic [DEPTH_BITS-1:0] r_paren, n_paren;
    logic [DEPTH_BITS-1:0] r_brace, n_brace;
    logic [LINE_BITS-1:0]  r_line,  n_line;
    logic [1:0]            r_semi,  n_semi;

    logic [LINE_BITS-1:0]  line_inc;
    logic [31:0]           line_wide;
    logic                  do_normal;

    // saturating line increment and the line as reported
    assign line_inc  = (r_line != {LINE_BITS{1'b1}}) ? r_line + 1'b1 : r_line;
    assign line_wide = 32'(r_line);

    // byte is handled as normal text, also when it breaks a keyword match
    assign do_normal = (r_mode == MODE_NORMAL)
                    || ((r_mode == MODE_F)  && (i_byte != CHAR_O))
                    || ((r_mode == MODE_FO) && (i_byte != CHAR_R));

    // next state and error
    always_comb begin
        n_mode  = r_mode;
        n_paren = r_paren;
        n_brace = r_brace;
        n_line  = r_line;
        n_semi  = r_semi;
        o_result.err  = 1'b0;
        o_result.kind = KIND_PAREN;
        o_result.line = (line_wide > 32'h0000_FFFF) ? {ERR_LINE_W{1'b1}}
                                                    : line_wide[ERR_LINE_W-1:0];

        // keyword match and header mode
        case (r_mode)
            MODE_HEADER: begin
                if (i_byte == CHAR_NL) begin
                    n_line = line_inc;
                end else if (i_byte == CHAR_SEMI) begin
                    if (r_semi != SEMI_MAX) begin
                        n_semi = r_semi + 2'd1;
                    end
                end else if (i_byte == CHAR_RPAREN) begin
                    o_result.err  = (r_semi != SEMI_GOOD);
                    o_result.kind = KIND_FOR;
                    n_semi        = 2'd0;
                    n_mode        = MODE_NORMAL;
                end
            end
            MODE_F: begin
                if (i_byte == CHAR_O) begin
                    n_mode = MODE_FO;
                end
            end
            MODE_FO: begin
                if (i_byte == CHAR_R) begin
                    n_mode = MODE_HEADER;
                    n_semi = 2'd0;
                end
            end
            default: begin
            end
        endcase

        // normal scanning: lines and bracket depths
        if (do_normal) begin
            if (i_byte == CHAR_NL) begin
                n_line = line_inc;
            end
            if (i_byte == CHAR_LPAREN) begin
                if (r_paren != {DEPTH_BITS{1'b1}}) begin
                    n_paren = r_paren + 1'b1;
                end
            end else if (i_byte == CHAR_RPAREN) begin
                if (r_paren == '0) begin
                    o_result.err  = 1'b1;
                    o_result.kind = KIND_PAREN;
                end else begin
                    n_paren = r_paren - 1'b1;
                end
            end else if (i_byte == CHAR_LBRACE) begin
                if (r_brace != {DEPTH_BITS{1'b1}}) begin
                    n_brace = r_brace + 1'b1;
                end
            end else if (i_byte == CHAR_RBRACE) begin
                if (r_brace == '0) begin
                    o_result.err  = 1'b1;
                    o_result.kind = KIND_BRACE;
                end else begin
                    n_brace = r_brace - 1'b1;
                end
            end
            n_mode = (i_byte == CHAR_F) ? MODE_F : MODE_NORMAL;
        end
    end

    // state registers, updated once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_paren <= '0;
            r_brace <= '0;
            r_line  <= LINE_BITS'(1);
            r_semi  <= 2'd0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_paren <= n_paren;
            r_brace <= n_brace;
            r_line  <= n_line;
            r_semi  <= n_semi;
        end
    end

endmodule

// ----- rtl/source_bracket_syntax_checker.sv -----
// path: an accepted beat is held in the input register; its error, if any, then loads into the result register
// throughput: one text byte per cycle while the result side does not stall; set by the input register
// feeding the scan logic and the result register, which can load while the result side drains
// a byte that raises no error gives no output beat
// reset: synchronous active low; depths, mode and count clear, line goes to one
module source_bracket_syntax_checker
    import sbc_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_error_kind,
    output logic [ERR_LINE_W-1:0] o_error_line
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    logic [1:0]            r_out_kind;
    logic [ERR_LINE_W-1:0] r_out_line;

    logic                  out_free;
    logic                  step;
    t_scan_result          result;

    // the result register can take a new value this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    // scan logic and state
    sbc_scan_core #(
        .DEPTH_BITS (DEPTH_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && result.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_kind <= result.kind;
            r_out_line <= result.line;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_error_kind = r_out_kind;
    assign o_error_line = r_out_line;

    // a held input beat is not dropped while the result side is stalled
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input beat lost during stall");

    // only defined error kinds leave the block
    a_kind_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_error_kind == KIND_PAREN || o_error_kind == KIND_BRACE
                         || o_error_kind == KIND_FOR))
        else $error("undefined error kind");

    // line numbers start at one
    a_line_nz : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_error_line != '0))
        else $error("error line is zero");

    // an error from a processed beat always reaches the result register
    a_err_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && result.err) |=> o_out_valid)
        else $error("error result dropped");

endmodule

// ----- tb/sbc_error_tracker.sv -----
`timescale 1ns / 100ps
// checker for the bracket checker: predicts every error beat from the text stream and compares
module sbc_error_tracker
    import sbc_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [1:0]            i_error_kind,
    input  logic [ERR_LINE_W-1:0] i_error_line,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [1:0]            kind;
        logic [ERR_LINE_W-1:0] line;
    } t_error_beat;

    localparam logic [DEPTH_BITS-1:0] DEPTH_TOP       = '1;
    localparam logic [LINE_BITS-1:0]  LINE_TOP        = '1;
    localparam longint unsigned       REPORT_LINE_TOP = (64'd1 << ERR_LINE_W) - 1;

    // shadow copy of the scanner state
    logic [1:0]            mode;
    logic [DEPTH_BITS-1:0] paren_lvl;
    logic [DEPTH_BITS-1:0] brace_lvl;
    logic [LINE_BITS-1:0]  line_no;
    logic [1:0]            semi_cnt;

    // error beats predicted but not yet seen on the output
    t_error_beat pending_errors[$];

    int fail_total = 0;
    int pend_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pend_total;

    task automatic log_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_total++;
    endtask

    // queue an error tagged with the current line, clipped to the report width
    task automatic note_error(input logic [1:0] kind);
        t_error_beat     e;
        longint unsigned ln;
        ln = line_no;
        if (ln > REPORT_LINE_TOP) begin
            ln = REPORT_LINE_TOP;
        end
        e.kind = kind;
        e.line = ln[ERR_LINE_W-1:0];
        pending_errors.push_back(e);
    endtask

    // line counter sticks at its top value
    task automatic count_line();
        if (line_no != LINE_TOP) begin
            line_no = line_no + 1'b1;
        end
    endtask

    // normal scanning: newlines, bracket depths, start of a keyword match
    task automatic scan_plain(input logic [7:0] b);
        if (b == CHAR_NL) begin
            count_line();
        end
        if (b == CHAR_LPAREN) begin
            if (paren_lvl != DEPTH_TOP) paren_lvl++;
        end else if (b == CHAR_RPAREN) begin
            if (paren_lvl == '0) note_error(KIND_PAREN);
            else paren_lvl--;
        end else if (b == CHAR_LBRACE) begin
            if (brace_lvl != DEPTH_TOP) brace_lvl++;
        end else if (b == CHAR_RBRACE) begin
            if (brace_lvl == '0) note_error(KIND_BRACE);
            else brace_lvl--;
        end
        mode = (b == CHAR_F) ? MODE_F : MODE_NORMAL;
    endtask

    // one text byte through the scanner
    task automatic scan_predict(input logic [7:0] b);
        case (mode)
            MODE_HEADER: begin
                if (b == CHAR_NL) begin
                    count_line();
                end else if (b == CHAR_SEMI) begin
                    if (semi_cnt != SEMI_MAX) semi_cnt++;
                end else if (b == CHAR_RPAREN) begin
                    if (semi_cnt != SEMI_GOOD) note_error(KIND_FOR);
                    semi_cnt = '0;
                    mode     = MODE_NORMAL;
                end
            end
            MODE_F: begin
                if (b == CHAR_O) mode = MODE_FO;
                else scan_plain(b);
            end
            MODE_FO: begin
                if (b == CHAR_R) begin
                    mode     = MODE_HEADER;
                    semi_cnt = '0;
                end else begin
                    scan_plain(b);
                end
            end
            default: begin
                scan_plain(b);
            end
        endcase
    endtask

    // output beats are checked before the input beat of the same edge is scanned
    always @(posedge i_clk) begin
        t_error_beat want;
        if (!i_rst_n) begin
            mode      = MODE_NORMAL;
            paren_lvl = '0;
            brace_lvl = '0;
            line_no   = LINE_BITS'(1);
            semi_cnt  = '0;
            pending_errors.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_errors.size() == 0) begin
                    log_mismatch($sformatf("unexpected error beat kind %0d line %0d",
                                           i_error_kind, i_error_line));
                end else begin
                    want = pending_errors.pop_front();
                    if (i_error_kind !== want.kind) begin
                        log_mismatch($sformatf("error kind %0d, want %0d (line %0d)",
                                               i_error_kind, want.kind, want.line));
                    end
                    if (i_error_line !== want.line) begin
                        log_mismatch($sformatf("error line %0d, want %0d (kind %0d)",
                                               i_error_line, want.line, want.kind));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                scan_predict(i_text_byte);
            end
        end
        pend_total = pending_errors.size();
    end

endmodule

// ----- tb/tb_source_bracket_syntax_checker.sv -----
`timescale 1ns / 100ps
// testbench top for the source bracket syntax checker: text stimulus, flow control, verdict
module tb_source_bracket_syntax_checker;
    import sbc_pkg::*;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_A       = 8'h61;
    localparam int         NEST_SPAN    = 258;
    localparam int         BRACE_SPAN   = 6;
    localparam int         RANDOM_BYTES = 200;
    localparam int         LIMIT_NS     = 20_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_text_byte;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_error_kind;
    logic [ERR_LINE_W-1:0] o_error_line;

    int fail_count;
    int pending_beats;
    int bytes_fed = 0;
    // chance out of 16 that a side idles before its next beat; zero means no idling
    int gap_odds  = 4;

    source_bracket_syntax_checker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_text_byte (i_text_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_error_kind(o_error_kind),
        .o_error_line(o_error_line)
    );

    sbc_error_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_text_byte (i_text_byte),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_error_kind(o_error_kind),
        .i_error_line(o_error_line),
        .o_fail_count(fail_count),
        .o_pending   (pending_beats)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // hard stop
    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // error side: ready with random stall bursts
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // one text beat, with an optional idle burst in front
    task automatic feed_byte(input logic [7:0] b);
        if (gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_fed++;
    endtask

    // harmless text: letters, blanks, newlines, opening parens
    function automatic logic [7:0] filler_char();
        case ($urandom_range(0, 7))
            0: return CHAR_NL;
            1: return CHAR_LPAREN;
            2: return CHAR_SPACE;
            default: return CHAR_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // one random fragment of source text
    task automatic emit_token();
        int semis;
        int fill;
        case ($urandom_range(0, 9))
            0: begin
                feed_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                feed_byte(filler_char());
            end
            2: begin
                feed_byte(CHAR_NL);
            end
            3: begin
                feed_byte(CHAR_LPAREN);
                repeat ($urandom_range(0, 3)) feed_byte(filler_char());
                feed_byte(CHAR_RPAREN);
            end
            4: begin
                feed_byte(CHAR_LBRACE);
                repeat ($urandom_range(0, 3)) feed_byte(filler_char());
                feed_byte(CHAR_RBRACE);
            end
            5, 6: begin
                // loop header, mostly well formed
                feed_byte(CHAR_F);
                feed_byte(CHAR_O);
                feed_byte(CHAR_R);
                if ($urandom_range(0, 3) != 0) feed_byte(CHAR_LPAREN);
                semis = ($urandom_range(0, 2) != 0) ? 2 : $urandom_range(0, 4);
                fill  = $urandom_range(0, 4);
                while (semis + fill > 0) begin
                    if (semis > 0 && (fill == 0 || $urandom_range(0, 1) == 1)) begin
                        feed_byte(CHAR_SEMI);
                        semis--;
                    end else begin
                        feed_byte(filler_char());
                        fill--;
                    end
                end
                feed_byte(CHAR_RPAREN);
            end
            7: begin
                feed_byte($urandom_range(0, 1) ? CHAR_RPAREN : CHAR_RBRACE);
            end
            8: begin
                // keyword match cut short
                feed_byte(CHAR_F);
                if ($urandom_range(0, 1)) feed_byte(CHAR_O);
                case ($urandom_range(0, 5))
                    0: feed_byte(CHAR_F);
                    1: feed_byte(CHAR_RPAREN);
                    2: feed_byte(CHAR_RBRACE);
                    3: feed_byte(CHAR_LPAREN);
                    4: feed_byte(CHAR_NL);
                    default: feed_byte(8'($urandom_range(0, 255)));
                endcase
            end
            default: begin
                repeat ($urandom_range(1, 4)) feed_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial begin
        int start_count;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_text_byte <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, stray closers, good and bad headers, broken match
        feed_byte(8'h00);
        feed_byte(8'hFF);
        feed_byte(CHAR_RPAREN);
        feed_byte(CHAR_RBRACE);
        feed_byte(CHAR_NL);
        feed_byte(CHAR_F);
        feed_byte(CHAR_O);
        feed_byte(CHAR_R);
        feed_byte(CHAR_LPAREN);
        feed_byte(CHAR_SEMI);
        feed_byte(CHAR_SEMI);
        feed_byte(CHAR_RPAREN);
        feed_byte(CHAR_F);
        feed_byte(CHAR_O);
        feed_byte(CHAR_RPAREN);
        feed_byte(CHAR_F);
        feed_byte(CHAR_F);
        feed_byte(CHAR_O);
        feed_byte(CHAR_R);
        feed_byte(CHAR_NL);
        feed_byte(CHAR_SEMI);
        feed_byte(CHAR_SEMI);
        feed_byte(CHAR_SEMI);
        feed_byte(CHAR_RPAREN);

        // paren nesting past the depth limit, then unwind below zero
        repeat (NEST_SPAN) feed_byte(CHAR_LPAREN);
        repeat (NEST_SPAN + 3) feed_byte(CHAR_RPAREN);
        // short brace nesting, then unwind below zero
        repeat (BRACE_SPAN) feed_byte(CHAR_LBRACE);
        repeat (BRACE_SPAN + 2) feed_byte(CHAR_RBRACE);

        // random text with changing idle pressure
        start_count = bytes_fed;
        while (bytes_fed - start_count < RANDOM_BYTES) begin
            if ($urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 2;
                    default: gap_odds = 6;
                endcase
            end
            emit_token();
        end

        // last part at full rate
        gap_odds = 0;
        feed_byte(CHAR_RPAREN);
        feed_byte(CHAR_RBRACE);
        feed_byte(CHAR_F);
        feed_byte(CHAR_O);
        feed_byte(CHAR_R);
        feed_byte(CHAR_SEMI);
        feed_byte(CHAR_RPAREN);
        repeat (30) emit_token();
        i_in_valid <= 1'b0;

        // drain outstanding error beats, then a short quiet tail
        @(negedge i_clk);
        while (pending_beats != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sbc_pkg.sv
rtl/sbc_scan_core.sv
rtl/source_bracket_syntax_checker.sv
tb/sbc_error_tracker.sv
tb/tb_source_bracket_syntax_checker.sv
